>>> design/hif_frame_receiver_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the frame receiver
// ---------------------------------------------------------------------------
`ifndef HIF_FRAME_RECEIVER_ASSERT_SVH
`define HIF_FRAME_RECEIVER_ASSERT_SVH
// implication checked on every clock, off during reset
`define HIF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define HIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/hif_pkg.sv
// ---------------------------------------------------------------------------
// hif_pkg
// shared types and constants of the frame receiver
// ---------------------------------------------------------------------------
package hif_pkg;
    localparam int BUFFER_BYTES_DEF = 32768;
    localparam int MAX_PACKETS_DEF  = 64;
    localparam int MAX_HEADERS_DEF  = 256;
    localparam int SLOT_COUNT_DEF   = 2;

    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_ERROR  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [2:0] KIND_WRITE    = 3'd0;
    localparam logic [2:0] KIND_STORED   = 3'd1;
    localparam logic [2:0] KIND_DROPPED  = 3'd2;
    localparam logic [2:0] KIND_COMPLETE = 3'd3;
    localparam logic [2:0] KIND_ABORT    = 3'd4;
    localparam logic [2:0] KIND_LIMIT    = 3'd5;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_STORE  = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic        slot;
        logic [14:0] address;
        logic [7:0]  wdata;
        logic [5:0]  packet_index;
        logic [47:0] header_word;
        logic [12:0] payload_length;
        logic [6:0]  packet_count;
        logic        last;
    } t_result;

    localparam int RES_W = $bits(t_result);
endpackage

>>> design/hif_front.sv
// ---------------------------------------------------------------------------
// hif_front
// frame state machine: classifies events and produces up to two results
// ---------------------------------------------------------------------------
module hif_front #(
    parameter int BUFFER_BYTES = hif_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_PACKETS  = hif_pkg::MAX_PACKETS_DEF,
    parameter int MAX_HEADERS  = hif_pkg::MAX_HEADERS_DEF,
    parameter int SLOT_COUNT   = hif_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_func,
    input  logic [7:0]        i_rx_byte,
    output logic [1:0]        o_count,
    output hif_pkg::t_result  o_res0,
    output hif_pkg::t_result  o_res1
);
    localparam int BU_W = $clog2(BUFFER_BYTES + 4100);
    localparam int PK_W = $clog2(MAX_PACKETS + 1);
    localparam int HA_W = $clog2(MAX_HEADERS + 1);
    localparam int SL_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic            r_active, n_active;
    logic [1:0]      r_phase, n_phase;
    logic [47:0]     r_hdr, n_hdr;
    logic [2:0]      r_fill, n_fill;
    logic [HA_W-1:0] r_att, n_att;
    logic [12:0]     r_left, n_left;
    logic [14:0]     r_pstart, n_pstart;
    logic [BU_W-1:0] r_used, n_used;
    logic [PK_W-1:0] r_pk, n_pk;
    logic [SL_W-1:0] r_slot, n_slot;

    logic [47:0] hw;
    logic [7:0]  sum;
    logic [11:0] len;
    logic [12:0] plen, cur_plen;
    logic [HA_W-1:0] att1;
    hif_pkg::t_result e;

    always_comb begin
        cur_plen = {1'b0, r_hdr[43:40], r_hdr[39:32]} + (r_hdr[20] ? 13'd4 : 13'd0);
        hw = (r_fill == 3'd0) ? 48'd0 : r_hdr;
        hw = hw | ({40'd0, i_rx_byte} << {r_fill, 3'b000});
        sum = hw[7:0] + hw[15:8] + hw[23:16] + hw[31:24] + hw[39:32] + hw[47:40];
        len = {hw[43:40], hw[39:32]};
        plen = {1'b0, len} + (hw[20] ? 13'd4 : 13'd0);
        att1 = r_att + 1'b1;
    end

    function automatic logic [SL_W-1:0] slot_inc(input logic [SL_W-1:0] s);
        logic [SL_W:0] t;
        t = {1'b0, s} + 1'b1;
        if (t >= (SL_W+1)'(SLOT_COUNT)) t = '0;
        return t[SL_W-1:0];
    endfunction

    always_comb begin
        n_active = r_active; n_phase = r_phase; n_hdr = r_hdr; n_fill = r_fill;
        n_att = r_att; n_left = r_left; n_pstart = r_pstart; n_used = r_used;
        n_pk = r_pk; n_slot = r_slot;
        o_count = 2'd0;
        e = '0;
        e.slot = r_slot[0];
        o_res0 = e;
        o_res1 = e;
        if (i_valid) begin
            if (i_func == hif_pkg::FUNC_START) begin
                n_active = 1'b1; n_phase = hif_pkg::PH_HEADER; n_hdr = '0; n_fill = '0;
                n_att = '0; n_left = '0; n_pstart = '0; n_used = '0; n_pk = '0;
            end else if (!r_active || i_func == hif_pkg::FUNC_UNUSED) begin
                n_active = r_active;
            end else if (i_func == hif_pkg::FUNC_ERROR) begin
                if (r_phase == hif_pkg::PH_HEADER) begin
                    n_fill = '0; n_hdr = '0; n_att = att1;
                    if (att1 >= HA_W'(MAX_HEADERS)) begin
                        o_count = 2'd1;
                        o_res0.kind = hif_pkg::KIND_LIMIT;
                        o_res0.packet_count = 7'(r_pk);
                        n_active = 1'b0; n_phase = hif_pkg::PH_HEADER; n_left = '0;
                        if (r_pk != '0) n_slot = slot_inc(r_slot);
                    end
                end else if (r_phase == hif_pkg::PH_STORE) begin
                    o_count = 2'd1;
                    o_res0.kind = hif_pkg::KIND_ABORT;
                    o_res0.header_word = r_hdr;
                    n_pk = '0; n_used = '0;
                    n_active = 1'b0; n_phase = hif_pkg::PH_HEADER; n_fill = '0; n_left = '0;
                end
            end else if (r_phase == hif_pkg::PH_HEADER) begin
                n_hdr = hw;
                n_fill = r_fill + 3'd1;
                if (r_fill == 3'd5) begin
                    n_fill = '0;
                    n_att = att1;
                    o_count = 2'd1;
                    o_res0.header_word = hw;
                    if (hw == '1 || hw == '0 ||
                        (sum == 8'hFF && hw[17:16] == 2'b11 && hw[31:24] == 8'h0C
                         && len == 12'd0)) begin
                        o_res0.kind = hif_pkg::KIND_COMPLETE;
                        o_res0.packet_count = 7'(r_pk);
                        n_active = 1'b0; n_left = '0;
                        n_slot = slot_inc(r_slot);
                    end else if (sum != 8'hFF) begin
                        o_res0.kind = hif_pkg::KIND_ABORT;
                        n_pk = '0; n_used = '0; n_active = 1'b0; n_left = '0;
                    end else if (len == 12'd0) begin
                        o_count = 2'd0;
                        if (att1 >= HA_W'(MAX_HEADERS)) begin
                            o_count = 2'd1;
                            o_res0 = e;
                            o_res0.kind = hif_pkg::KIND_LIMIT;
                            o_res0.packet_count = 7'(r_pk);
                            n_active = 1'b0; n_left = '0;
                            if (r_pk != '0) n_slot = slot_inc(r_slot);
                        end
                    end else begin
                        n_left = plen;
                        o_res0.payload_length = plen;
                        if (r_used + BU_W'(plen) > BU_W'(BUFFER_BYTES)
                            || r_pk >= PK_W'(MAX_PACKETS)) begin
                            n_phase = hif_pkg::PH_SKIP;
                            o_res0.kind = hif_pkg::KIND_DROPPED;
                        end else begin
                            n_phase = hif_pkg::PH_STORE;
                            n_pstart = 15'(r_used);
                            o_res0.kind = hif_pkg::KIND_STORED;
                            o_res0.address = 15'(r_used);
                            o_res0.packet_index = 6'(r_pk);
                            n_used = r_used + BU_W'(plen);
                            n_pk = r_pk + 1'b1;
                        end
                    end
                end
            end else begin
                if (r_phase == hif_pkg::PH_STORE) begin
                    o_count = 2'd1;
                    o_res0.kind = hif_pkg::KIND_WRITE;
                    o_res0.address = r_pstart + 15'(cur_plen - r_left);
                    o_res0.wdata = i_rx_byte;
                    o_res0.packet_index = 6'(r_pk - 1'b1);
                end
                if (r_left <= 13'd1) begin
                    n_left = '0; n_phase = hif_pkg::PH_HEADER; n_fill = '0;
                    if (r_att >= HA_W'(MAX_HEADERS)) begin
                        if (r_phase == hif_pkg::PH_STORE) begin
                            o_count = 2'd2;
                            o_res1.kind = hif_pkg::KIND_LIMIT;
                            o_res1.packet_count = 7'(r_pk);
                        end else begin
                            o_count = 2'd1;
                            o_res0.kind = hif_pkg::KIND_LIMIT;
                            o_res0.packet_count = 7'(r_pk);
                        end
                        n_active = 1'b0;
                        if (r_pk != '0) n_slot = slot_inc(r_slot);
                    end
                end else begin
                    n_left = r_left - 13'd1;
                end
            end
        end
        if (o_count == 2'd1) o_res0.last = 1'b1;
        if (o_count == 2'd2) o_res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0; r_phase <= hif_pkg::PH_HEADER; r_hdr <= '0; r_fill <= '0;
            r_att <= '0; r_left <= '0; r_pstart <= '0; r_used <= '0; r_pk <= '0;
            r_slot <= '0;
        end else begin
            r_active <= n_active; r_phase <= n_phase; r_hdr <= n_hdr; r_fill <= n_fill;
            r_att <= n_att; r_left <= n_left; r_pstart <= n_pstart; r_used <= n_used;
            r_pk <= n_pk; r_slot <= n_slot;
        end
    end
endmodule

>>> design/hif_queue.sv
// ---------------------------------------------------------------------------
// hif_queue
// result queue: takes up to two results per cycle, delivers one per pop
// ---------------------------------------------------------------------------
module hif_queue #(
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_count,
    input  hif_pkg::t_result i_res0,
    input  hif_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_room2,
    output hif_pkg::t_result o_head
);
    localparam int AW = $clog2(DEPTH);
    hif_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          pop;

    assign o_empty = (r_cnt == '0);
    assign o_room2 = (r_cnt <= (AW+1)'(DEPTH - 2));
    assign o_head  = r_mem[r_rp];
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wp] <= i_res0;
        if (i_count == 2'd2) r_mem[r_wp + 1'b1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_count);
            r_rp  <= r_rp + AW'(pop);
            r_cnt <= r_cnt + (AW+1)'(i_count) - (AW+1)'(pop);
        end
    end
endmodule

>>> design/hif_frame_receiver.sv
// ---------------------------------------------------------------------------
// hif_frame_receiver
// frame receiver for 6-byte link headers and their payloads
// ---------------------------------------------------------------------------
// One event is taken every cycle while full is low; each event is classified
// in the cycle it is pushed and its zero to two results enter an 8-entry queue
// the next edge. full rises only when the queue has room for fewer than two
// results, so throughput is one event per cycle while results are popped.
module hif_frame_receiver #(
    parameter int BUFFER_BYTES = hif_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_PACKETS  = hif_pkg::MAX_PACKETS_DEF,
    parameter int MAX_HEADERS  = hif_pkg::MAX_HEADERS_DEF,
    parameter int SLOT_COUNT   = hif_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic        o_slot,
    output logic [14:0] o_address,
    output logic [7:0]  o_wdata,
    output logic [5:0]  o_packet_index,
    output logic [47:0] o_header_word,
    output logic [12:0] o_payload_length,
    output logic [6:0]  o_packet_count,
    output logic        o_last
);
    `include "hif_frame_receiver_assert.svh"

    logic [1:0] cnt;
    logic room2;
    hif_pkg::t_result res0, res1, head;

    assign full = !room2;

    hif_front #(.BUFFER_BYTES(BUFFER_BYTES), .MAX_PACKETS(MAX_PACKETS),
                .MAX_HEADERS(MAX_HEADERS), .SLOT_COUNT(SLOT_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(push && !full),
        .i_func(i_func), .i_rx_byte(i_rx_byte),
        .o_count(cnt), .o_res0(res0), .o_res1(res1)
    );

    hif_queue #(.DEPTH(8)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_count(cnt), .i_res0(res0),
        .i_res1(res1), .i_pop(pop), .o_empty(empty), .o_room2(room2), .o_head(head)
    );

    assign o_kind = head.kind;
    assign o_slot = head.slot;
    assign o_address = head.address;
    assign o_wdata = head.wdata;
    assign o_packet_index = head.packet_index;
    assign o_header_word = head.header_word;
    assign o_payload_length = head.payload_length;
    assign o_packet_count = head.packet_count;
    assign o_last = head.last;

    `HIF_ASSERT_IMPL(a_no_res_idle, i_clk, i_rst_n, !(push && !full), cnt == 2'd0)
    `HIF_ASSERT_NEXT(a_res_fills, i_clk, i_rst_n, cnt != 2'd0, !empty)
    `HIF_ASSERT_IMPL(a_two_write, i_clk, i_rst_n, cnt == 2'd2,
                     res0.kind == hif_pkg::KIND_WRITE && res1.last)
endmodule
